// File: src/mexp_pkg.sv
// shared constants, command and status types for the modular exponentiation block
package mexp_pkg;

  localparam int OPERAND_BITS = 63;
  localparam int BASE_W = 64;
  localparam int RAW_W = BASE_W - 1;
  localparam int RES_W = 63;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 4;
  localparam int ALIGN_SH = RAW_W - OPERAND_BITS;
  localparam int CNT_W = $clog2(RAW_W);
  localparam int BIT_W = $clog2(OPERAND_BITS);

  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_RED_STEP,
    CMD_RED_END,
    CMD_START_PROD,
    CMD_START_SQR,
    CMD_MUL_STEP,
    CMD_SAVE_PROD,
    CMD_SAVE_B,
    CMD_OUT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic    err;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic e_bit;
  } dp_status_t;

endpackage

// File: src/mexp_datapath.sv
// operand registers, bit-serial reduction and modular multiply, result register
module mexp_datapath (
  input  logic                               clk_i,
  input  mexp_pkg::dp_cmd_t                  cmd_i,
  output mexp_pkg::dp_status_t               status_o,
  input  logic [mexp_pkg::BASE_W-1:0]        base_i,
  input  logic [mexp_pkg::OPERAND_BITS-1:0]  modulus_i,
  input  logic [mexp_pkg::OPERAND_BITS-1:0]  exponent_i,
  output logic [mexp_pkg::RES_W-1:0]         result_o,
  output logic                               failed_o
);
  import mexp_pkg::*;

  localparam int N = OPERAND_BITS;

  logic [N-1:0]     acc_q, acc_d;
  logic [N-1:0]     x_q, x_d;
  logic [N-1:0]     b_q, b_d;
  logic [N-1:0]     prod_q, prod_d;
  logic [N-1:0]     e_q, e_d;
  logic [RAW_W-1:0] y_q, y_d;
  logic [RES_W-1:0] result_q, result_d;
  logic             failed_q, failed_d;

  logic [N:0]       m_ext;
  logic [N:0]       red_r, red_v;
  logic [N:0]       dbl, dbl_m, sum, sum_m;
  logic [N-1:0]     one_mod;
  logic [RAW_W-1:0] y_shift, y_from_b;

  always_comb begin
    m_ext    = {1'b0, modulus_i};
    red_r    = {acc_q, y_q[RAW_W-1]};
    red_v    = (red_r >= m_ext) ? red_r - m_ext : red_r;
    dbl      = {acc_q, 1'b0};
    dbl_m    = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum      = dbl_m + {1'b0, x_q};
    sum_m    = (sum >= m_ext) ? sum - m_ext : sum;
    one_mod  = (modulus_i == N'(1)) ? '0 : N'(1);
    y_shift  = {y_q[RAW_W-2:0], 1'b0};
    y_from_b = RAW_W'(b_q) << ALIGN_SH;
  end

  always_comb begin
    acc_d    = acc_q;
    x_d      = x_q;
    b_d      = b_q;
    prod_d   = prod_q;
    e_d      = e_q;
    y_d      = y_q;
    result_d = result_q;
    failed_d = failed_q;
    case (cmd_i.op)
      CMD_LOAD: begin
        acc_d = '0;
        y_d   = base_i[RAW_W-1:0];
        e_d   = exponent_i;
      end
      CMD_RED_STEP: begin
        acc_d = red_v[N-1:0];
        y_d   = y_shift;
      end
      CMD_RED_END: begin
        b_d    = acc_q;
        prod_d = one_mod;
      end
      CMD_START_PROD: begin
        acc_d = '0;
        x_d   = prod_q;
        y_d   = y_from_b;
      end
      CMD_START_SQR: begin
        acc_d = '0;
        x_d   = b_q;
        y_d   = y_from_b;
      end
      CMD_MUL_STEP: begin
        acc_d = y_q[RAW_W-1] ? sum_m[N-1:0] : dbl_m[N-1:0];
        y_d   = y_shift;
      end
      CMD_SAVE_PROD: begin
        prod_d = acc_q;
        acc_d  = '0;
        x_d    = b_q;
        y_d    = y_from_b;
      end
      CMD_SAVE_B: begin
        b_d = acc_q;
        e_d = e_q >> 1;
      end
      CMD_OUT: begin
        result_d = cmd_i.err ? '0 : RES_W'(prod_q);
        failed_d = cmd_i.err;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    x_q      <= x_d;
    b_q      <= b_d;
    prod_q   <= prod_d;
    e_q      <= e_d;
    y_q      <= y_d;
    result_q <= result_d;
    failed_q <= failed_d;
  end

  assign status_o.err   = base_i[BASE_W-1] | (modulus_i == '0);
  assign status_o.e_bit = e_q[0];
  assign result_o       = result_q;
  assign failed_o       = failed_q;

endmodule

// File: src/mexp_ctrl.sv
// sequencer for reduction, square-and-multiply steps and result handoff
module mexp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  mexp_pkg::dp_status_t  status_i,
  output mexp_pkg::dp_cmd_t     cmd_o
);
  import mexp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_RED_END,
    S_SEL,
    S_MULP,
    S_PEND,
    S_MULS,
    S_SEND,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BIT_W-1:0] k_q, k_d;
  logic             err_q, err_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    err_d       = err_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o.op    = CMD_NOP;
    cmd_o.err   = err_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          err_d    = status_i.err;
          cnt_d    = '0;
          state_d  = status_i.err ? S_DONE : S_RED;
        end
      end
      S_RED: begin
        cmd_o.op = CMD_RED_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(RAW_W - 1)) begin
          state_d = S_RED_END;
        end
      end
      S_RED_END: begin
        cmd_o.op = CMD_RED_END;
        k_d      = '0;
        state_d  = S_SEL;
      end
      S_SEL: begin
        cnt_d = '0;
        if (status_i.e_bit) begin
          cmd_o.op = CMD_START_PROD;
          state_d  = S_MULP;
        end else begin
          cmd_o.op = CMD_START_SQR;
          state_d  = S_MULS;
        end
      end
      S_MULP: begin
        cmd_o.op = CMD_MUL_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(OPERAND_BITS - 1)) begin
          state_d = S_PEND;
        end
      end
      S_PEND: begin
        cmd_o.op = CMD_SAVE_PROD;
        cnt_d    = '0;
        state_d  = S_MULS;
      end
      S_MULS: begin
        cmd_o.op = CMD_MUL_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(OPERAND_BITS - 1)) begin
          state_d = S_SEND;
        end
      end
      S_SEND: begin
        cmd_o.op = CMD_SAVE_B;
        k_d      = k_q + 1'b1;
        state_d  = (k_q == BIT_W'(OPERAND_BITS - 1)) ? S_DONE : S_SEL;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // rejected request skips all arithmetic
  a_err_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && status_i.err) |=> (state_q == S_DONE && err_q))
    else $error("error request did not go straight to result");

  // result handed to the output register when it is free
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || !out_stall_i)) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not loaded");

  // step counter stays within operand length during multiplies
  a_mul_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MULP || state_q == S_MULS) |-> (cnt_q < CNT_W'(OPERAND_BITS)))
    else $error("multiply step counter overrun");

  // an error request never enters the arithmetic states
  a_err_no_math: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && state_q != S_IDLE) |-> (state_q == S_DONE))
    else $error("error request entered arithmetic");

endmodule

// File: src/modular_exponentiation.sv
// modular exponentiation top level: config registers, sequencer and datapath
//
// Input channel: in_valid_i / in_stall_o carry one signed 64-bit base per request.
// Output channel: out_valid_o / out_stall_i carry result_o and failed_o.
// Config port: APB-style, 64-bit data; modulus at byte address 0, exponent at 8.
// Only write the registers while no request is in flight.
// A negative base or a zero modulus returns failed_o = 1 and result_o = 0.
// Otherwise the base is first reduced modulo the modulus bit-serially, then the
// exponent is scanned from its low bit. Each of the 63 exponent bits costs a select
// state, one bit-serial modular squaring and, where the bit is set, one modular
// multiply; both take one multiplier bit per cycle in a shared double-and-add
// unit.
// One request is worked on at a time; the next is taken once the result sits in
// the output register, which holds it for as long as out_stall_i is high.
// Reset clears both registers to zero and empties the output register.
module modular_exponentiation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [mexp_pkg::BASE_W-1:0]  base_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mexp_pkg::RES_W-1:0]          result_o,
  output logic                                failed_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mexp_pkg::ADDR_W-1:0]         paddr,
  input  logic [mexp_pkg::DATA_W-1:0]         pwdata,
  output logic [mexp_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import mexp_pkg::*;

  logic [OPERAND_BITS-1:0] modulus_q, modulus_d;
  logic [OPERAND_BITS-1:0] exponent_q, exponent_d;
  logic                    wr_en;
  logic                    reg_sel;
  dp_cmd_t                 cmd;
  dp_status_t              status;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[ADDR_W-1];

  always_comb begin
    modulus_d  = modulus_q;
    exponent_d = exponent_q;
    if (wr_en) begin
      case (reg_sel)
        REG_MODULUS:  modulus_d  = pwdata[OPERAND_BITS-1:0];
        REG_EXPONENT: exponent_d = pwdata[OPERAND_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= '0;
      exponent_q <= '0;
    end else begin
      modulus_q  <= modulus_d;
      exponent_q <= exponent_d;
    end
  end

  assign prdata = (reg_sel == REG_EXPONENT) ? DATA_W'(exponent_q) : DATA_W'(modulus_q);

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mexp_datapath u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .base_i     (base_i),
    .modulus_i  (modulus_q),
    .exponent_i (exponent_q),
    .result_o   (result_o),
    .failed_o   (failed_o)
  );

endmodule

// File: tb/sv/modular_exponentiation_tb.sv
// testbench for modular_exponentiation: directed and random bases against a predictor
`timescale 1ns / 1ps

module modular_exponentiation_tb;
  import mexp_pkg::*;

  typedef logic [RES_W-1:0] operand_t;

  typedef struct packed {
    operand_t result;
    logic     failed;
  } mexp_result_t;

  localparam int MAX_LATENCY = 67 + 63 * 130;
  localparam int SETTLE_CYCLES = 16;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [BASE_W-1:0] base;
  logic                     out_valid;
  logic                     out_stall;
  operand_t                 result;
  logic                     failed;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  operand_t     modulus_cfg;
  operand_t     exponent_cfg;
  mexp_result_t expected_q[$];
  mexp_result_t want;
  int           errors;
  bit           idle_on;
  int           sink_wait;
  int           sink_hold;

  modular_exponentiation i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .base_i     (base),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .result_o   (result),
    .failed_o   (failed),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // base ** exponent mod modulus with exact wide products
  function automatic mexp_result_t mod_power(logic [BASE_W-1:0] b);
    mexp_result_t r;
    logic [127:0] acc;
    logic [127:0] sq;
    r.failed = b[BASE_W-1] || (modulus_cfg == '0);
    r.result = '0;
    if (!r.failed) begin
      sq = 128'(b) % 128'(modulus_cfg);
      acc = 128'd1 % 128'(modulus_cfg);
      for (int k = 0; k < RES_W; k++) begin
        if (exponent_cfg[k]) begin
          acc = (acc * sq) % 128'(modulus_cfg);
        end
        sq = (sq * sq) % 128'(modulus_cfg);
      end
      r.result = acc[RES_W-1:0];
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: result=%0d failed=%0b", $time, result, failed);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (failed !== want.failed) begin
          $display("%0t: failed mismatch: expected %0b, actual %0b", $time, want.failed, failed);
          errors++;
        end
        if (result !== want.result) begin
          $display("%0t: result mismatch: expected %0d, actual %0d", $time, want.result, result);
          errors++;
        end
      end
    end
  end

  // output side stall: per result wait, plus long hold on request
  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      sink_wait <= idle_on ? $urandom_range(0, 8) : 0;
    end else if (out_valid && out_stall && sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
    end
  end

  always @(negedge clk_i) begin
    out_stall <= (sink_hold > 0) || (sink_wait > 0);
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end
  end

  task automatic apb_access(input logic sel, input logic wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = ADDR_W'({sel, 3'b000});
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_register(input logic sel, input operand_t value);
    logic [DATA_W-1:0] rd;
    apb_access(sel, 1'b0, '0, rd);
    if (rd !== DATA_W'(value)) begin
      $display("%0t: register %0d readback: expected %0d, actual %0d", $time, sel, value, rd);
      errors++;
    end
  endtask

  task automatic configure(input logic [DATA_W-1:0] mod_word, input logic [DATA_W-1:0] exp_word);
    logic [DATA_W-1:0] rd;
    apb_access(REG_MODULUS, 1'b1, mod_word, rd);
    apb_access(REG_EXPONENT, 1'b1, exp_word, rd);
    modulus_cfg = mod_word[RES_W-1:0];
    exponent_cfg = exp_word[RES_W-1:0];
    check_register(REG_MODULUS, modulus_cfg);
    check_register(REG_EXPONENT, exponent_cfg);
  endtask

  task automatic send_base(input logic [BASE_W-1:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid = 1'b1;
    base = b;
    expected_q.push_back(mod_power(b));
    do @(posedge clk_i); while (in_stall);
  endtask

  // sender pauses until every request has its result
  task automatic drain();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    check_register(REG_MODULUS, '0);
    check_register(REG_EXPONENT, '0);
    modulus_cfg = '0;
    exponent_cfg = '0;
    send_base(64'd0);
    send_base(64'd7);
    send_base(64'h7fff_ffff_ffff_ffff);
    send_base(64'h8000_0000_0000_0000);
    drain();
  endtask

  task automatic test_negative_base();
    configure(64'd3233, 64'd17);
    send_base(64'hffff_ffff_ffff_ffff);
    send_base(64'h8000_0000_0000_0000);
    send_base(64'd65);
    drain();
  endtask

  task automatic test_zero_exponent();
    configure(64'd1, 64'd0);
    send_base(64'd5);
    drain();
    configure(64'd97, 64'd0);
    send_base(64'd0);
    send_base(64'd12345);
    drain();
    configure(64'd1, 64'd65537);
    send_base(64'd9);
    drain();
  endtask

  task automatic test_extreme_operands();
    // top bit of each write is dropped by the register
    configure(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_base(64'd0);
    send_base(64'd1);
    send_base(64'd2);
    send_base(64'h7fff_ffff_ffff_fffe);
    send_base(64'h7fff_ffff_ffff_ffff);
    drain();
  endtask

  task automatic test_base_reduction();
    configure(64'd1000003, 64'd3);
    send_base(64'h7fff_ffff_ffff_ffff);
    send_base(64'd1000003);
    send_base(64'd1000004);
    send_base(64'd2000011);
    drain();
  endtask

  task automatic test_output_backpressure();
    configure(64'd0, 64'd5);
    @(posedge clk_i);
    sink_hold = 400;
    for (int i = 0; i < 8; i++) begin
      send_base({$urandom, $urandom});
    end
    drain();
  endtask

  task automatic test_random_traffic();
    logic [DATA_W-1:0] mod_word;
    logic [DATA_W-1:0] exp_word;
    logic [BASE_W-1:0] b;
    operand_t          r;
    for (int phase = 0; phase < 6; phase++) begin
      idle_on = (phase != 3);
      case ($urandom_range(0, 9))
        0: mod_word = 64'd1;
        1, 2: mod_word = 64'($urandom_range(2, 5000));
        3, 4: mod_word = {32'd0, $urandom};
        5: mod_word = 64'h7fff_ffff_ffff_ffff;
        6: mod_word = 64'd0;
        default: mod_word = {$urandom, $urandom};
      endcase
      mod_word[DATA_W-1] = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: exp_word = 64'($urandom_range(0, 3));
        1: exp_word = 64'd65537;
        2: exp_word = 64'h7fff_ffff_ffff_ffff;
        default: exp_word = {$urandom, $urandom};
      endcase
      exp_word[DATA_W-1] = 1'($urandom_range(0, 1));
      configure(mod_word, exp_word);
      for (int i = 0; i < 12; i++) begin
        r = operand_t'({$urandom, $urandom});
        case ($urandom_range(0, 9))
          0: b = {1'b1, r};
          1: b = 64'($urandom_range(0, 3));
          2: b = {1'b0, modulus_cfg} + 64'($urandom_range(0, 2)) - 64'd1;
          3, 4: b = {1'b0, r};
          default: b = (modulus_cfg == '0) ? {1'b0, r} : {1'b0, r % modulus_cfg};
        endcase
        send_base(b);
      end
      drain();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    base = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    idle_on = 1'b1;
    sink_wait = 0;
    sink_hold = 0;
    modulus_cfg = '0;
    exponent_cfg = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_negative_base();
    test_zero_exponent();
    test_extreme_operands();
    test_base_reduction();
    test_output_backpressure();
    test_random_traffic();

    drain();
    repeat (MAX_LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
src/mexp_pkg.sv
src/mexp_datapath.sv
src/mexp_ctrl.sv
src/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
